// ===== rtl/tie_averaged_ranking_assert.svh =====
// Assertion macros for the tie-averaged ranking block.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef TIE_AVERAGED_RANKING_ASSERT_SVH
`define TIE_AVERAGED_RANKING_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TAR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define TAR_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tar_pkg.sv =====
// Shared constants, types and key mapping for the tie-averaged ranking block.
// No dependencies.
package tar_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_WIDTH = 32;
	localparam int SAMPLE_W  = 32;
	localparam int RANK_W    = 8;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int DR_W      = CNT_W + 1;

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [DR_W-1:0]      drank_t;

	// Flip the sign bit so that unsigned order matches two's complement order.
	function automatic key_t order_key(input logic [SAMPLE_W-1:0] raw);
		key_t sign_bit;
		sign_bit = key_t'(1) << (KEY_WIDTH - 1);
		return raw[KEY_WIDTH-1:0] ^ sign_bit;
	endfunction

endpackage

// ===== rtl/tar_in_if.sv =====
// Input channel of the tie-averaged ranking block: one sample per beat.
// Depends on tar_pkg.
interface tar_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tar_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source(output valid, sample, last_sample, input ready);
	modport sink(input valid, sample, last_sample, output ready);
endinterface

// ===== rtl/tar_out_if.sv =====
// Output channel of the tie-averaged ranking block: one rank per beat.
// Depends on tar_pkg.
interface tar_out_if;
	logic                         valid;
	logic                         ready;
	logic [tar_pkg::RANK_W-1:0]   doubled_rank;
	logic                         any_ties;
	logic                         overflowed;
	logic                         last_rank;

	modport source(output valid, doubled_rank, any_ties, overflowed, last_rank, input ready);
	modport sink(input valid, doubled_rank, any_ties, overflowed, last_rank, output ready);
endinterface

// ===== rtl/tar_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tie_averaged_ranking.sv =====
// Tie-averaged ranking: load signed keys until a last beat, then emit ranks in input order.
// Load: a beat arriving with keys already stored is accepted, then a tie scan over the store
// runs before the next beat is taken; a beat into an empty store, or a dropped beat, needs no scan.
// Rank: the single RAM read port scans the whole store once per result, and each result waits
// for the output register to be free; the first rank follows the last load beat.
// Reset clears counters, flags and the FSM; store contents stay undefined, no clear pass.
// Depends on tar_pkg, tar_in_if, tar_out_if, tar_ram and tie_averaged_ranking_assert.svh.
`include "tie_averaged_ranking_assert.svh"

module tie_averaged_ranking (
	input  logic       clk,
	input  logic       arst_n,
	tar_in_if.sink     samples,
	tar_out_if.source  ranks
);

	// IDLE takes samples; SCAN_TIE compares a new key against earlier keys;
	// FETCH/MINE pick up the key being ranked; SCAN_RANK counts smaller and
	// equal keys; RANK_OUT hands the result to the output register.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_TIE,
		ST_FETCH,
		ST_MINE,
		ST_SCAN_RANK,
		ST_RANK_OUT
	} state_t;

	state_t               state_q;
	tar_pkg::cnt_t        count_q;
	logic                 tie_q;
	logic                 ovf_q;
	logic                 last_q;
	tar_pkg::key_t        key_q;
	tar_pkg::cnt_t        rd_q;
	tar_pkg::cnt_t        end_q;
	logic                 rd_v_s1;
	tar_pkg::addr_t       idx_q;
	tar_pkg::cnt_t        below_q;
	tar_pkg::cnt_t        equal_q;

	logic                       out_valid_q;
	logic [tar_pkg::RANK_W-1:0] out_rank_q;
	logic                       out_ties_q;
	logic                       out_ovf_q;
	logic                       out_last_q;

	logic             in_acc;
	logic             has_room;
	tar_pkg::key_t    new_key;
	logic             scanning;
	logic             issue;
	logic             scan_done;
	logic             out_free;
	logic             out_load;
	logic             last_idx;
	tar_pkg::drank_t  rank_full;

	logic             ram_we;
	logic             ram_re;
	tar_pkg::addr_t   ram_raddr;
	tar_pkg::key_t    ram_rdata;

	// Handshake and scan control
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign has_room      = count_q < tar_pkg::cnt_t'(tar_pkg::MAX_ITEMS);
	assign new_key       = tar_pkg::order_key(samples.sample);

	assign scanning  = (state_q == ST_SCAN_TIE) || (state_q == ST_SCAN_RANK);
	assign issue     = scanning && (rd_q != end_q);
	// All reads issued and the last one compared.
	assign scan_done = (rd_q == end_q) && !rd_v_s1;

	assign out_free  = !out_valid_q || ranks.ready;
	assign out_load  = (state_q == ST_RANK_OUT) && out_free;
	assign last_idx  = (tar_pkg::cnt_t'(idx_q) + tar_pkg::cnt_t'(1)) == count_q;
	// Twice the smaller count, plus equal count (self included), plus one.
	assign rank_full = {below_q, 1'b0} + tar_pkg::drank_t'(equal_q) + tar_pkg::drank_t'(1);

	// Store: write the new key on the load beat, read one entry per cycle while scanning.
	assign ram_we    = in_acc && has_room;
	assign ram_re    = issue || (state_q == ST_FETCH);
	assign ram_raddr = (state_q == ST_FETCH) ? idx_q : rd_q[tar_pkg::ADDR_W-1:0];

	tar_ram #(
		.WIDTH(tar_pkg::KEY_WIDTH),
		.DEPTH(tar_pkg::MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[tar_pkg::ADDR_W-1:0]),
		.wdata (new_key),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			tie_q       <= 1'b0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			key_q       <= '0;
			rd_q        <= '0;
			end_q       <= '0;
			rd_v_s1     <= 1'b0;
			idx_q       <= '0;
			below_q     <= '0;
			equal_q     <= '0;
			out_valid_q <= 1'b0;
			out_rank_q  <= '0;
			out_ties_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// Read data is valid in the cycle after an issued scan read.
			rd_v_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + tar_pkg::cnt_t'(1);
			end
			// Load a finished rank into the output beat; drop the held beat once it is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (ranks.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= samples.last_sample;
						if (has_room) begin
							key_q   <= new_key;
							count_q <= count_q + tar_pkg::cnt_t'(1);
							if (count_q != '0) begin
								rd_q    <= '0;
								end_q   <= count_q;
								state_q <= ST_SCAN_TIE;
							end else if (samples.last_sample) begin
								idx_q   <= '0;
								state_q <= ST_FETCH;
							end
						end else begin
							// Store full: drop the sample but honor its last mark.
							ovf_q <= 1'b1;
							if (samples.last_sample) begin
								idx_q   <= '0;
								state_q <= ST_FETCH;
							end
						end
					end
				end
				ST_SCAN_TIE: begin
					if (rd_v_s1 && (ram_rdata == key_q)) begin
						tie_q <= 1'b1;
					end
					if (scan_done) begin
						if (last_q) begin
							idx_q   <= '0;
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_MINE;
				end
				ST_MINE: begin
					key_q   <= ram_rdata;
					below_q <= '0;
					equal_q <= '0;
					rd_q    <= '0;
					end_q   <= count_q;
					state_q <= ST_SCAN_RANK;
				end
				ST_SCAN_RANK: begin
					if (rd_v_s1) begin
						if (ram_rdata < key_q) begin
							below_q <= below_q + tar_pkg::cnt_t'(1);
						end else if (ram_rdata == key_q) begin
							equal_q <= equal_q + tar_pkg::cnt_t'(1);
						end
					end
					if (scan_done) begin
						state_q <= ST_RANK_OUT;
					end
				end
				ST_RANK_OUT: begin
					if (out_free) begin
						out_rank_q  <= tar_pkg::RANK_W'(rank_full);
						out_ties_q  <= tie_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= last_idx;
						if (last_idx) begin
							// Run complete: clear for the next data set.
							count_q <= '0;
							tie_q   <= 1'b0;
							ovf_q   <= 1'b0;
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + tar_pkg::addr_t'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ranks.valid        = out_valid_q;
	assign ranks.doubled_rank = out_rank_q;
	assign ranks.any_ties     = out_ties_q;
	assign ranks.overflowed   = out_ovf_q;
	assign ranks.last_rank    = out_last_q;

	// Store fill never passes capacity.
	`TAR_ASSERT_ALWAYS(a_count_cap, count_q <= tar_pkg::cnt_t'(tar_pkg::MAX_ITEMS), "count over capacity")
	// A stored key with earlier keys present must be checked for ties.
	`TAR_ASSERT_NEXT(a_tie_scan_entry, in_acc && has_room && (count_q != '0), state_q == ST_SCAN_TIE, "tie scan skipped")
	// Every ranked key matches at least itself.
	`TAR_ASSERT_ALWAYS(a_self_match, (state_q != ST_RANK_OUT) || (equal_q != '0), "rank scan missed own key")
	// Scan read pointer stays within the scan range.
	`TAR_ASSERT_ALWAYS(a_scan_bound, rd_q <= end_q, "scan pointer past end")

endmodule
